>>> rtl/crs_pkg.sv
// ----------------------------------------------------------------------------
// crs_pkg
// Shared types and constants for the chinese remainder solver.
// ----------------------------------------------------------------------------
package crs_pkg;

   // widths fixed by the item fields
   localparam int FIELD_W  = 8;
   localparam int PROD_W   = 64;
   localparam int STATUS_W = 2;

   // default configuration
   localparam int MAX_PAIRS_DEF = 8;
   localparam int MOD_BITS_DEF  = 8;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 2'd0,
      ST_NO_INVERSE  = 2'd1,
      ST_BAD_MODULUS = 2'd2,
      ST_TOO_MANY    = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_LOAD,
      S_RD,
      S_RDW,
      S_DIV1,
      S_PMOD,
      S_INV,
      S_DIV2,
      S_MUL,
      S_ROOM,
      S_ACC,
      S_DONE
   } state_type;

endpackage

>>> rtl/crs_ram.sv
// ----------------------------------------------------------------------------
// crs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module crs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/crs_div.sv
// ----------------------------------------------------------------------------
// crs_div
// Restoring bit-serial divider: wide dividend by a narrow divisor, one
// quotient bit per cycle, gives quotient and remainder.
// ----------------------------------------------------------------------------
module crs_div #(
   parameter int MOD_BITS = crs_pkg::MOD_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [crs_pkg::PROD_W-1:0] dividend,
   input  logic [MOD_BITS-1:0]       divisor,
   output logic                      done,
   output logic [crs_pkg::PROD_W-1:0] quotient,
   output logic [MOD_BITS-1:0]       remainder
);
   import crs_pkg::*;

   localparam int CW = $clog2(PROD_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [PROD_W-1:0]   q_ff, q_in;
   logic [MOD_BITS-1:0] rem_ff, rem_in;
   logic [MOD_BITS-1:0] d_ff, d_in;
   logic [MOD_BITS:0]   trial;
   logic                ge;

   // one shift-subtract step
   always_comb begin
      trial   = {rem_ff, q_ff[PROD_W-1]};
      ge      = (trial >= {1'b0, d_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      d_in    = d_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(PROD_W - 1);
         q_in    = dividend;
         rem_in  = '0;
         d_in    = divisor;
      end else if (busy_ff) begin
         q_in   = {q_ff[PROD_W-2:0], ge};
         rem_in = ge ? MOD_BITS'(trial - {1'b0, d_ff}) : trial[MOD_BITS-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      d_ff   <= d_in;
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = rem_ff;

endmodule

>>> rtl/chinese_remainder_solver.sv
// ----------------------------------------------------------------------------
// chinese_remainder_solver
// Stores congruence pairs in two RAMs while building the combined modulus,
// then solves the set with a shared serial divider and an inverse search.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  req     | in        | residue, modulus, last_pair
//  rsp     | out       | solution, combined_modulus, status
//
//  a pair that does not close a set is accepted, and stored unless the set is
//  full; a closing pair after a load error goes straight to the result, else
//  it starts the solve: per stored pair a read and a read-wait step, three
//  divider passes, an inverse search over the candidates below the modulus,
//  then multiply, room and accumulate steps, and the done state hands over
//  the result; reset clears the set state; the RAMs need no clearing
//  a result waiting on rsp stalls only the end of the next solve, not loading
module chinese_remainder_solver #(
   parameter int MAX_PAIRS = crs_pkg::MAX_PAIRS_DEF,
   parameter int MOD_BITS  = crs_pkg::MOD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [crs_pkg::FIELD_W-1:0]  req_residue,
   input  logic [crs_pkg::FIELD_W-1:0]  req_modulus,
   input  logic                         req_last_pair,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [crs_pkg::PROD_W-1:0]   rsp_solution,
   output logic [crs_pkg::PROD_W-1:0]   rsp_combined_modulus,
   output logic [crs_pkg::STATUS_W-1:0] rsp_status
);
   import crs_pkg::*;

   localparam int AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
   localparam int CW = $clog2(MAX_PAIRS + 1);

   state_type           state_ff, state_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   status_type          err_ff, err_in;
   status_type          stat_ff, stat_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [MOD_BITS-1:0] mi_ff, mi_in;
   logic [MOD_BITS-1:0] bi_ff, bi_in;
   logic [PROD_W-1:0]   part_ff, part_in;
   logic [MOD_BITS-1:0] r_ff, r_in;
   logic [MOD_BITS-1:0] acc_ff, acc_in;
   logic [MOD_BITS-1:0] k_ff, k_in;
   logic [MOD_BITS-1:0] t_ff, t_in;
   logic [PROD_W-1:0]   term_ff, term_in;
   logic [PROD_W-1:0]   room_ff, room_in;
   logic [PROD_W-1:0]   sol_ff, sol_in;
   logic                rspv_ff, rspv_in;
   logic [PROD_W-1:0]   rsol_ff, rsol_in;
   logic [PROD_W-1:0]   rmod_ff, rmod_in;
   logic [STATUS_W-1:0] rstat_ff, rstat_in;

   logic                accept;
   logic [MOD_BITS-1:0] b_in, m_in;
   logic                full;
   logic                we;
   logic [MOD_BITS-1:0] res_rd, mod_rd;
   logic                div_start, div_done;
   logic [PROD_W-1:0]   div_dividend, div_q;
   logic [MOD_BITS-1:0] div_divisor, div_rem;
   logic [2*MOD_BITS-1:0] bk;
   logic [MOD_BITS:0]   acc_sum;
   logic                slot_free;

   assign req_ready = (state_ff == S_LOAD);
   assign accept    = req_valid && req_ready;
   assign b_in      = req_residue[MOD_BITS-1:0];
   assign m_in      = req_modulus[MOD_BITS-1:0];
   assign full      = (cnt_ff == CW'(MAX_PAIRS));
   assign we        = accept && !full;
   assign slot_free = !rspv_ff || rsp_ready;
   assign bk        = {{MOD_BITS{1'b0}}, bi_ff} * {{MOD_BITS{1'b0}}, k_ff};
   assign acc_sum   = {1'b0, acc_ff} + {1'b0, r_ff};

   // pair stores
   crs_ram #(.WIDTH(MOD_BITS), .DEPTH(MAX_PAIRS)) u_res_ram (
      .clock (clock),
      .we    (we),
      .waddr (cnt_ff[AW-1:0]),
      .wdata (b_in),
      .raddr (idx_ff[AW-1:0]),
      .rdata (res_rd)
   );

   crs_ram #(.WIDTH(MOD_BITS), .DEPTH(MAX_PAIRS)) u_mod_ram (
      .clock (clock),
      .we    (we),
      .waddr (cnt_ff[AW-1:0]),
      .wdata (m_in),
      .raddr (idx_ff[AW-1:0]),
      .rdata (mod_rd)
   );

   // shared divider
   crs_div #(.MOD_BITS(MOD_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_rem)
   );

   // divider requests
   always_comb begin
      div_start    = 1'b0;
      div_dividend = prod_ff;
      div_divisor  = mod_rd;
      if (state_ff == S_RDW) begin
         div_start = 1'b1;
      end else if (state_ff == S_DIV1 && div_done) begin
         // partial product reduced by its own modulus
         div_start    = 1'b1;
         div_dividend = div_q;
         div_divisor  = mi_ff;
      end else if (state_ff == S_INV && acc_ff == MOD_BITS'(1)) begin
         div_start    = 1'b1;
         div_dividend = {{(PROD_W-2*MOD_BITS){1'b0}}, bk};
         div_divisor  = mi_ff;
      end
   end

   // load-side error update
   always_comb begin
      err_in = err_ff;
      if (accept) begin
         if (full) begin
            if (err_ff == ST_OK) err_in = ST_TOO_MANY;
         end else if (m_in < MOD_BITS'(2) && err_ff == ST_OK) begin
            err_in = ST_BAD_MODULUS;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_LOAD: begin
            if (accept && req_last_pair) state_in = (err_in == ST_OK) ? S_RD : S_DONE;
         end
         S_RD:   state_in = S_RDW;
         S_RDW:  state_in = S_DIV1;
         S_DIV1: if (div_done) state_in = S_PMOD;
         S_PMOD: if (div_done) state_in = S_INV;
         S_INV: begin
            if (acc_ff == MOD_BITS'(1)) state_in = S_DIV2;
            else if (k_ff == mi_ff - 1'b1) state_in = S_DONE;
         end
         S_DIV2: if (div_done) state_in = S_MUL;
         S_MUL:  state_in = S_ROOM;
         S_ROOM: state_in = S_ACC;
         S_ACC:  state_in = (idx_ff + 1'b1 == cnt_ff) ? S_DONE : S_RD;
         S_DONE: if (slot_free) state_in = S_LOAD;
         default: state_in = S_LOAD;
      endcase
   end

   // datapath
   always_comb begin
      cnt_in   = cnt_ff;
      prod_in  = prod_ff;
      stat_in  = stat_ff;
      idx_in   = idx_ff;
      mi_in    = mi_ff;
      bi_in    = bi_ff;
      part_in  = part_ff;
      r_in     = r_ff;
      acc_in   = acc_ff;
      k_in     = k_ff;
      t_in     = t_ff;
      term_in  = term_ff;
      room_in  = room_ff;
      sol_in   = sol_ff;
      rspv_in  = rspv_ff && !rsp_ready;
      rsol_in  = rsol_ff;
      rmod_in  = rmod_ff;
      rstat_in = rstat_ff;
      case (state_ff)
         S_LOAD: begin
            if (we) begin
               cnt_in  = cnt_ff + 1'b1;
               prod_in = prod_ff * {{(PROD_W-MOD_BITS){1'b0}}, m_in};
            end
            stat_in = err_in;
            idx_in  = '0;
            sol_in  = '0;
         end
         S_RDW: begin
            mi_in = mod_rd;
            bi_in = res_rd;
         end
         S_DIV1: part_in = div_q;
         S_PMOD: begin
            r_in   = div_rem;
            acc_in = div_rem;
            k_in   = MOD_BITS'(1);
         end
         S_INV: begin
            if (acc_ff != MOD_BITS'(1)) begin
               if (k_ff == mi_ff - 1'b1) begin
                  stat_in = ST_NO_INVERSE;
               end
               acc_in = (acc_sum >= {1'b0, mi_ff}) ? MOD_BITS'(acc_sum - {1'b0, mi_ff})
                                                  : acc_sum[MOD_BITS-1:0];
               k_in   = k_ff + 1'b1;
            end
         end
         S_DIV2: t_in = div_rem;
         S_MUL:  term_in = part_ff * {{(PROD_W-MOD_BITS){1'b0}}, t_ff};
         S_ROOM: room_in = prod_ff - term_ff;
         S_ACC: begin
            sol_in = (sol_ff >= room_ff) ? sol_ff - room_ff : sol_ff + term_ff;
            idx_in = idx_ff + 1'b1;
         end
         S_DONE: begin
            if (slot_free) begin
               rspv_in  = 1'b1;
               rsol_in  = (stat_ff == ST_OK) ? sol_ff : '0;
               rmod_in  = prod_ff;
               rstat_in = stat_ff;
               cnt_in   = '0;
               prod_in  = PROD_W'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         cnt_ff   <= '0;
         prod_ff  <= PROD_W'(1);
         err_ff   <= ST_OK;
         rspv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         prod_ff  <= prod_in;
         err_ff   <= (state_ff == S_DONE && slot_free) ? ST_OK : err_in;
         rspv_ff  <= rspv_in;
      end
      stat_ff  <= stat_in;
      idx_ff   <= idx_in;
      mi_ff    <= mi_in;
      bi_ff    <= bi_in;
      part_ff  <= part_in;
      r_ff     <= r_in;
      acc_ff   <= acc_in;
      k_ff     <= k_in;
      t_ff     <= t_in;
      term_ff  <= term_in;
      room_ff  <= room_in;
      sol_ff   <= sol_in;
      rsol_ff  <= rsol_in;
      rmod_ff  <= rmod_in;
      rstat_ff <= rstat_in;
   end

   assign rsp_valid            = rspv_ff;
   assign rsp_solution         = rsol_ff;
   assign rsp_combined_modulus = rmod_ff;
   assign rsp_status           = rstat_ff;

endmodule
